@@ rtl/tpg_pkg.sv @@
// Shared types and constants for the triangle panel geometry block.
`default_nettype none
package tpg_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W       = $clog2(VERTEX_COUNT);
  localparam int VTX_W        = 96;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } tpg_op_t;

  typedef struct packed {
    tpg_op_t            opcode;
    logic [9:0]         vertex_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } tpg_in_t;

  typedef struct packed {
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic signed [31:0] centroid_z;
    logic [33:0]        bound_radius;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [50:0]        area;
    logic               degenerate;
  } tpg_out_t;

  typedef enum logic {
    UOP_SQRT = 1'b0,
    UOP_DIV  = 1'b1
  } tpg_uop_t;

  typedef struct packed {
    logic     start;
    tpg_uop_t op;
  } tpg_ureq_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIV3,
    S_RAD,
    S_SQR_R,
    S_CROSS,
    S_MAG,
    S_SHIFT,
    S_NORM,
    S_SQR_A,
    S_N2,
    S_SQR_L,
    S_NDIV,
    S_FIN
  } tpg_state_t;

endpackage
`default_nettype wire

@@ rtl/tpg_vtx_mem.sv @@
// Vertex store: one write port, one registered read port.
`default_nettype none
module tpg_vtx_mem import tpg_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [VIDX_W-1:0] waddr,
  input  logic [VTX_W-1:0]  wdata,
  input  logic [VIDX_W-1:0] raddr,
  output logic [VTX_W-1:0]  rdata
);

  logic [VTX_W-1:0] mem [VERTEX_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tpg_mul.sv @@
// Shared registered 33x33 unsigned multiplier.
`default_nettype none
module tpg_mul import tpg_pkg::*; (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ rtl/tpg_iter_unit.sv @@
// Bit-serial square root and divide unit, one result bit per cycle.
`default_nettype none
module tpg_iter_unit import tpg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tpg_ureq_t    req,
  input  logic [127:0] n,
  input  logic [63:0]  c,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  res
);

  logic         active;
  logic         is_div;
  logic [5:0]   cnt;
  logic [65:0]  rem;
  logic [127:0] nsh;
  logic [63:0]  dsr;
  logic [65:0]  rem_s;
  logic [65:0]  trial;
  logic [65:0]  diff;
  logic         ge;

  always_comb begin
    if (is_div) begin
      rem_s = {rem[64:0], nsh[127]};
      trial = {2'b00, dsr};
    end else begin
      rem_s = {rem[63:0], nsh[127:126]};
      trial = {res, 2'b01};
    end
    ge   = (rem_s >= trial);
    diff = rem_s - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        is_div <= (req.op == UOP_DIV);
        res    <= '0;
        dsr    <= den;
        if (req.op == UOP_DIV) begin
          // quotient fits 31 bits, so start with the top of the dividend
          rem <= {3'b000, c[63:1]};
          nsh <= {c[0], 127'b0};
          cnt <= 6'd30;
        end else begin
          rem <= '0;
          nsh <= n;
          cnt <= 6'd63;
        end
      end else if (active) begin
        rem <= ge ? diff : rem_s;
        res <= {res[62:0], ge};
        nsh <= is_div ? {nsh[126:0], 1'b0} : {nsh[125:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/triangle_panel_geometry.sv @@
// Top level: vertex table and triangle geometry sequencer.
`default_nettype none
// A store item (opcode store) writes one vertex into the table and gives no
// result; busy stays low. A compute item reads its three corners from the
// read port of the vertex memory and then walks a fixed sequence: centroid
// by a multiply with the reciprocal of three, built from five shift-add
// steps and one final add, squared corner distances, cross-product terms and
// squared-length terms on one shared 33x33 multiplier, three square roots
// and three normal divisions on one shared unit that makes one result bit
// per cycle. A degenerate triangle (zero cross product) skips the area and
// normal steps. busy is high for the whole sequence, and the result strobe
// done rises as busy falls. The result is shown on result with done high
// for exactly one cycle; result keeps its value but done is not held, so
// take it in that cycle. A corner read from a slot never stored since reset
// gives an undefined result.
module triangle_panel_geometry import tpg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  tpg_in_t  item,
  output logic     busy,
  output logic     done,
  output tpg_out_t result
);

  tpg_state_t state, state_next;

  logic [5:0]  cnt;
  logic [3:0]  idx;
  logic        ph;

  // memory side
  logic              mem_we;
  logic [VIDX_W-1:0] mem_waddr;
  logic [VIDX_W-1:0] mem_raddr;
  logic [VTX_W-1:0]  mem_rdata;
  logic              rd_oob;
  logic              rd_oob_q;
  logic [9:0]        corner [3];

  // datapath registers
  logic signed [31:0] v [3][3];
  logic [98:0]        u3 [3];
  logic [34:0]        s3 [3];
  logic signed [31:0] cen [3];
  logic [65:0]        d2;
  logic [65:0]        best;
  logic [33:0]        radius;
  logic signed [66:0] cr [3];
  logic [63:0]        cmag [3];
  logic               cneg [3];
  logic [63:0]        cval [3];
  logic [129:0]       acc;
  logic [50:0]        area;
  logic [63:0]        len;
  logic [31:0]        normq [3];
  logic               degen;

  // cross differences
  logic signed [32:0] ea [3];
  logic signed [32:0] eb [3];

  // multiplier
  logic [32:0]  ma, mb;
  logic [65:0]  mp;
  logic         sneg;
  logic [1:0]   rsel, csel;
  logic [129:0] pp;
  logic signed [66:0] sp;

  // root / divide unit
  tpg_ureq_t    ureq;
  logic [127:0] un;
  logic [63:0]  uc;
  logic         udone;
  logic [63:0]  ures;

  logic [63:0]  mx;
  logic         accept;

  function automatic logic [1:0] row3(input logic [3:0] i);
    logic [1:0] r;
    if (i >= 4'd6) begin
      r = 2'd2;
    end else if (i >= 4'd3) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  function automatic logic [1:0] col3(input logic [3:0] i);
    logic [3:0] t;
    t = i - {row3(i), 1'b0} - {2'b00, row3(i)};
    return t[1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign cen[k] = u3[k][95:64];
    assign ea[k]  = {v[1][k][31], v[1][k]} - {v[0][k][31], v[0][k]};
    assign eb[k]  = {v[2][k][31], v[2][k]} - {v[0][k][31], v[0][k]};
  end

  assign mx = (cmag[0] > cmag[1]) ? ((cmag[0] > cmag[2]) ? cmag[0] : cmag[2])
                                  : ((cmag[1] > cmag[2]) ? cmag[1] : cmag[2]);

  // store path writes straight through; compute path reads one corner a cycle
  assign mem_we    = accept && (item.opcode == OP_STORE) &&
                     (32'(item.vertex_index) < VERTEX_COUNT);
  assign mem_waddr = VIDX_W'(item.vertex_index);

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    mem_raddr = VIDX_W'(corner[0]);
      2'd1:    mem_raddr = VIDX_W'(corner[1]);
      default: mem_raddr = VIDX_W'(corner[2]);
    endcase
    unique case (cnt[1:0])
      2'd0:    rd_oob = (32'(corner[0]) >= VERTEX_COUNT);
      2'd1:    rd_oob = (32'(corner[1]) >= VERTEX_COUNT);
      default: rd_oob = (32'(corner[2]) >= VERTEX_COUNT);
    endcase
  end

  tpg_vtx_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({item.coord_z, item.coord_y, item.coord_x}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // operand selection for the shared multiplier
  always_comb begin
    logic signed [32:0] dd;
    logic [32:0]        dmag;
    logic [1:0]         ai, bi;
    logic [63:0]        nv;
    ma   = '0;
    mb   = '0;
    sneg = 1'b0;
    ai   = 2'd0;
    bi   = 2'd0;
    rsel = row3(idx);
    csel = col3(idx);
    dd   = {v[rsel][csel][31], v[rsel][csel]} - {cen[csel][31], cen[csel]};
    dmag = dd[32] ? (33'd0 - dd) : dd;
    nv   = (state == S_NORM) ? cmag[rsel] : cval[rsel];
    unique case (idx[2:0])
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      default: begin ai = 2'd1; bi = 2'd0; end
    endcase
    unique case (state)
      S_RAD: begin
        ma = dmag;
        mb = dmag;
      end
      S_CROSS: begin
        ma   = ea[ai][32] ? (33'd0 - ea[ai]) : ea[ai];
        mb   = eb[bi][32] ? (33'd0 - eb[bi]) : eb[bi];
        sneg = ea[ai][32] ^ eb[bi][32];
      end
      S_NORM, S_N2: begin
        unique case (csel)
          2'd0:    begin ma = {1'b0, nv[31:0]};  mb = {1'b0, nv[31:0]};  end
          2'd1:    begin ma = {1'b0, nv[63:32]}; mb = {1'b0, nv[31:0]};  end
          default: begin ma = {1'b0, nv[63:32]}; mb = {1'b0, nv[63:32]}; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    // square of a 64-bit value from 32-bit halves: lo*lo, 2*hi*lo, hi*hi
    unique case (csel)
      2'd0:    pp = {64'b0, mp};
      2'd1:    pp = {64'b0, mp} << 33;
      default: pp = {64'b0, mp} << 64;
    endcase
    sp = sneg ? (67'sd0 - $signed({1'b0, mp})) : $signed({1'b0, mp});
  end

  tpg_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (mp)
  );

  // root / divide unit requests
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = UOP_SQRT;
    un         = '0;
    uc         = cval[idx[1:0]];
    unique case (state)
      S_SQR_R: begin
        ureq.start = !ph;
        un         = {62'b0, best};
      end
      S_SQR_A: begin
        ureq.start = !ph;
        un         = {32'b0, acc[129:34]};
      end
      S_SQR_L: begin
        ureq.start = !ph;
        un         = acc[127:0];
      end
      S_NDIV: begin
        ureq.start = !ph;
        ureq.op    = UOP_DIV;
      end
      default: begin
        ureq.start = 1'b0;
      end
    endcase
  end

  tpg_iter_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .n    (un),
    .c    (uc),
    .den  (len),
    .done (udone),
    .res  (ures)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (item.opcode == OP_COMPUTE)) begin
          state_next = S_READ;
        end
      end
      S_READ:  if (cnt == 6'd3) state_next = S_SUM;
      S_SUM:   state_next = S_DIV3;
      S_DIV3:  if (cnt == 6'd5) state_next = S_RAD;
      S_RAD:   if (ph && (idx == 4'd8)) state_next = S_SQR_R;
      S_SQR_R: if (ph && udone) state_next = S_CROSS;
      S_CROSS: if (ph && (idx == 4'd5)) state_next = S_MAG;
      S_MAG:   state_next = S_SHIFT;
      S_SHIFT: state_next = (mx == 64'd0) ? S_FIN : S_NORM;
      S_NORM:  if (ph && (idx == 4'd8)) state_next = S_SQR_A;
      S_SQR_A: if (ph && udone) state_next = S_N2;
      S_N2:    if (ph && (idx == 4'd8)) state_next = S_SQR_L;
      S_SQR_L: if (ph && udone) state_next = S_NDIV;
      S_NDIV:  if (ph && udone && (idx == 4'd2)) state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencing counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      idx  <= '0;
      ph   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      if (state_next != state) begin
        cnt <= '0;
        idx <= '0;
        ph  <= 1'b0;
      end else begin
        unique case (state)
          S_READ, S_DIV3: cnt <= cnt + 6'd1;
          S_RAD, S_CROSS, S_NORM, S_N2: begin
            ph <= !ph;
            if (ph) begin
              idx <= idx + 4'd1;
            end
          end
          S_SQR_R, S_SQR_A, S_SQR_L: ph <= 1'b1;
          S_NDIV: begin
            if (!ph) begin
              ph <= 1'b1;
            end else if (udone) begin
              ph  <= 1'b0;
              idx <= idx + 4'd1;
            end
          end
          default: cnt <= cnt;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [65:0]  d2n;
    logic [34:0]  sb;
    logic [1:0]   vi;
    logic [66:0]  amag;
    logic [1:0]   sft;
    rd_oob_q <= rd_oob;
    vi       = cnt[1:0] - 2'd1;
    if (accept) begin
      corner[0] <= item.corner_a;
      corner[1] <= item.corner_b;
      corner[2] <= item.corner_c;
    end
    unique case (state)
      S_READ: begin
        if (cnt != 6'd0) begin
          v[vi][0] <= rd_oob_q ? 32'sd0 : mem_rdata[31:0];
          v[vi][1] <= rd_oob_q ? 32'sd0 : mem_rdata[63:32];
          v[vi][2] <= rd_oob_q ? 32'sd0 : mem_rdata[95:64];
        end
      end
      S_SUM: begin
        // bias the sum so the divide by three works on a nonnegative value
        for (int k = 0; k < 3; k++) begin
          sb = {{3{v[0][k][31]}}, v[0][k]} + {{3{v[1][k][31]}}, v[1][k]} +
               {{3{v[2][k][31]}}, v[2][k]} + 35'h600000000;
          s3[k] <= sb;
          u3[k] <= {64'b0, sb};
        end
        best <= '0;
      end
      S_DIV3: begin
        // multiply by (2^64 + 2) / 3 = (1+4)(1+16)(1+2^8)(1+2^16)(1+2^32) + 1,
        // one shift-add a cycle; the quotient lands in bits 98:64
        for (int k = 0; k < 3; k++) begin
          unique case (cnt[2:0])
            3'd0:    u3[k] <= u3[k] + (u3[k] << 2);
            3'd1:    u3[k] <= u3[k] + (u3[k] << 4);
            3'd2:    u3[k] <= u3[k] + (u3[k] << 8);
            3'd3:    u3[k] <= u3[k] + (u3[k] << 16);
            3'd4:    u3[k] <= u3[k] + (u3[k] << 32);
            default: u3[k] <= u3[k] + {64'b0, s3[k]};
          endcase
        end
      end
      S_RAD: begin
        if (ph) begin
          d2n = ((csel == 2'd0) ? 66'd0 : d2) + mp;
          d2  <= d2n;
          if ((csel == 2'd2) && (d2n >= best)) begin
            best <= d2n;
          end
        end
      end
      S_SQR_R: if (ph && udone) radius <= ures[33:0];
      S_CROSS: begin
        if (ph) begin
          if (!idx[0]) begin
            cr[idx[2:1]] <= sp;
          end else begin
            cr[idx[2:1]] <= cr[idx[2:1]] - sp;
          end
        end
      end
      S_MAG: begin
        for (int k = 0; k < 3; k++) begin
          amag    = cr[k][66] ? (67'd0 - cr[k]) : cr[k];
          cmag[k] <= amag[63:0];
          cneg[k] <= cr[k][66];
        end
      end
      S_SHIFT: begin
        // keep the squared lengths below 2^126
        degen <= (mx == 64'd0);
        if (mx[63]) begin
          sft = 2'd2;
        end else if (mx[62]) begin
          sft = 2'd1;
        end else begin
          sft = 2'd0;
        end
        for (int k = 0; k < 3; k++) begin
          cval[k] <= cmag[k] >> sft;
        end
      end
      S_NORM, S_N2: begin
        if (ph) begin
          acc <= ((idx == 4'd0) ? 130'd0 : acc) + pp;
        end
      end
      S_SQR_A: if (ph && udone) area <= ures[50:0];
      S_SQR_L: if (ph && udone) len <= ures;
      S_NDIV: begin
        if (ph && udone) begin
          normq[idx[1:0]] <= cneg[idx[1:0]] ? (32'd0 - {1'b0, ures[30:0]})
                                            : {1'b0, ures[30:0]};
        end
      end
      S_FIN: begin
        result.centroid_x   <= cen[0];
        result.centroid_y   <= cen[1];
        result.centroid_z   <= cen[2];
        result.bound_radius <= radius;
        result.normal_x     <= degen ? 32'sd0 : normq[0];
        result.normal_y     <= degen ? 32'sd0 : normq[1];
        result.normal_z     <= degen ? 32'sd0 : normq[2];
        result.area         <= degen ? 51'd0 : area;
        result.degenerate   <= degen;
      end
      default: d2 <= d2;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_compute_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode == OP_COMPUTE)) |=> busy)
    else $error("compute item accepted but block not busy");

  a_store_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode == OP_STORE)) |=> !busy && !done)
    else $error("store item started a computation");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.normal_x == 32'sd0) && (result.normal_y == 32'sd0) &&
      (result.normal_z == 32'sd0) && (result.area == 51'd0))
    else $error("degenerate result with nonzero normal or area");

  a_normal_bound: assert property (@(posedge clk) disable iff (rst)
    (done && !result.degenerate) |->
      (result.normal_x <= 32'sh40000000) && (result.normal_x >= -32'sh40000000))
    else $error("normal component beyond unit length");
`endif

endmodule
`default_nettype wire

@@ tb/triangle_panel_geometry_test.sv @@
// Testbench for the triangle panel geometry block: vertex stores and triangle results.
`timescale 1ns / 1ps
module triangle_panel_geometry_test;
  import tpg_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  tpg_in_t  item = '0;
  logic     busy;
  logic     done;
  tpg_out_t result;

  triangle_panel_geometry dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // Predictor copy of the vertex memory, plus a record of written slots so
  // that no compute item ever names a slot that was never stored.
  logic signed [31:0] vtx_mem [VERTEX_COUNT][3];
  bit                 vtx_known [VERTEX_COUNT];
  int                 known_slots [$];

  tpg_out_t pending_results [$];
  int       mismatch_count = 0;
  int       result_count = 0;
  int       degen_count = 0;
  int       store_count = 0;
  int       compute_count = 0;

  // Floor square root of an unsigned 130-bit value.
  function automatic logic [129:0] floor_root(logic [129:0] n);
    logic [129:0] res;
    logic [129:0] bitv;
    logic [129:0] t;
    res = '0;
    bitv = 130'd1 << 128;
    while (bitv > n && bitv != 0) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Work out the triangle result from the corner slots.
  function automatic tpg_out_t triangle_geometry(logic [9:0] ca, logic [9:0] cb,
                                                 logic [9:0] cc);
    tpg_out_t r;
    logic signed [63:0] v [3][3];
    logic signed [63:0] cen [3];
    logic signed [63:0] sum, q, d;
    logic signed [63:0] ea [3];
    logic signed [63:0] eb [3];
    logic signed [129:0] cr [3];
    logic [129:0] mag [3];
    logic [129:0] d2, best, nrm, mx, c, n2, len, quo;
    logic [9:0] idx [3];
    int s;
    idx[0] = ca; idx[1] = cb; idx[2] = cc;
    r = '0;
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < 3; k++)
        v[j][k] = (idx[j] < VERTEX_COUNT) ? 64'(vtx_mem[idx[j]][k]) : 64'sd0;
    for (int k = 0; k < 3; k++) begin
      sum = v[0][k] + v[1][k] + v[2][k];
      q = sum / 3;
      if (sum % 3 < 0) q = q - 1;
      cen[k] = q;
    end
    r.centroid_x = cen[0][31:0];
    r.centroid_y = cen[1][31:0];
    r.centroid_z = cen[2][31:0];
    best = '0;
    for (int j = 0; j < 3; j++) begin
      d2 = '0;
      for (int k = 0; k < 3; k++) begin
        d = v[j][k] - cen[k];
        if (d < 0) d = -d;
        d2 = d2 + 130'(d) * 130'(d);
      end
      if (d2 >= best) best = d2;
    end
    r.bound_radius = 34'(floor_root(best));
    for (int k = 0; k < 3; k++) begin
      ea[k] = v[1][k] - v[0][k];
      eb[k] = v[2][k] - v[0][k];
    end
    cr[0] = 130'(ea[1]) * 130'(eb[2]) - 130'(ea[2]) * 130'(eb[1]);
    cr[1] = 130'(ea[2]) * 130'(eb[0]) - 130'(ea[0]) * 130'(eb[2]);
    cr[2] = 130'(ea[0]) * 130'(eb[1]) - 130'(ea[1]) * 130'(eb[0]);
    mx = '0;
    nrm = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (cr[k] < 0) ? 130'(-cr[k]) : 130'(cr[k]);
      if (mag[k] > mx) mx = mag[k];
      nrm = nrm + mag[k] * mag[k];
    end
    if (mx == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.area = 51'(floor_root(nrm >> 34));
    s = 0;
    while ((mx >> s) >= (130'd1 << 62)) s++;
    n2 = '0;
    for (int k = 0; k < 3; k++) begin
      c = mag[k] >> s;
      n2 = n2 + c * c;
    end
    len = floor_root(n2);
    for (int k = 0; k < 3; k++) begin
      quo = ((mag[k] >> s) << 30) / len;
      if (cr[k] < 0) quo = -quo;
      case (k)
        0: r.normal_x = quo[31:0];
        1: r.normal_y = quo[31:0];
        default: r.normal_z = quo[31:0];
      endcase
    end
    return r;
  endfunction

  // Sample results at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    tpg_out_t want;
    if (!rst && done) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p actual %p", want, result);
        end
      end
    end
  end

  // Hand over one item at the next free edge; log the prediction at acceptance.
  task automatic send_item(tpg_in_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.opcode == OP_STORE) begin
      store_count++;
      if (it.vertex_index < VERTEX_COUNT) begin
        vtx_mem[it.vertex_index][0] = it.coord_x;
        vtx_mem[it.vertex_index][1] = it.coord_y;
        vtx_mem[it.vertex_index][2] = it.coord_z;
        if (!vtx_known[it.vertex_index]) known_slots.push_back(it.vertex_index);
        vtx_known[it.vertex_index] = 1'b1;
      end
    end else begin
      compute_count++;
      pending_results.push_back(triangle_geometry(it.corner_a, it.corner_b, it.corner_c));
    end
  endtask

  task automatic drop_start();
    start <= 1'b0;
    item  <= '0;
  endtask

  function automatic tpg_in_t store_item(int slot, int x, int y, int z);
    tpg_in_t it;
    it = '0;
    it.opcode = OP_STORE;
    it.vertex_index = 10'(slot);
    it.coord_x = x; it.coord_y = y; it.coord_z = z;
    it.corner_a = 10'($urandom); it.corner_b = 10'($urandom); it.corner_c = 10'($urandom);
    return it;
  endfunction

  function automatic tpg_in_t compute_item(int a, int b, int c);
    tpg_in_t it;
    it = '0;
    it.opcode = OP_COMPUTE;
    it.vertex_index = 10'($urandom);
    it.coord_x = $urandom; it.coord_y = $urandom; it.coord_z = $urandom;
    it.corner_a = 10'(a); it.corner_b = 10'(b); it.corner_c = 10'(c);
    return it;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $signed(32'($urandom_range(0, 8))) - 4;
      2: return $signed($urandom) >>> $urandom_range(8, 20);
      default: return $urandom;
    endcase
  endfunction

  // Directed table row: item plus an optional typed-in expectation.
  typedef struct {
    tpg_in_t  it;
    bit       has_fixed;
    tpg_out_t fixed;
  } stim_row_t;

  stim_row_t directed_rows [$];

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    tpg_out_t zero_res;
    tpg_in_t it;
    int drained;
    int burst;
    int slot;
    int last_results;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    zero_res = '0;
    zero_res.degenerate = 1'b1;
    // Directed rows: origin, extremes, a unit triangle, collinear and
    // repeated corners, the last table slot, and ignored fields.
    row.has_fixed = 0; row.fixed = '0;
    row.it = store_item(0, 0, 0, 0);                                  directed_rows.push_back(row);
    row.it = store_item(1, 32'h10000, 0, 0);                          directed_rows.push_back(row);
    row.it = store_item(2, 0, 32'h10000, 0);                          directed_rows.push_back(row);
    row.it = store_item(3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff); directed_rows.push_back(row);
    row.it = store_item(4, 32'h80000000, 32'h80000000, 32'h80000000); directed_rows.push_back(row);
    row.it = store_item(5, 32'h7fffffff, 32'h80000000, 32'h7fffffff); directed_rows.push_back(row);
    row.it = store_item(1023, 32'h80000000, 32'h7fffffff, 0);         directed_rows.push_back(row);
    row.it = store_item(6, 32'h20000, 0, 0);                          directed_rows.push_back(row);
    row.has_fixed = 1; row.fixed = zero_res;
    row.it = compute_item(0, 0, 0);                                   directed_rows.push_back(row);
    row.has_fixed = 0;
    row.it = compute_item(0, 1, 2);                                   directed_rows.push_back(row);
    row.it = compute_item(0, 2, 1);                                   directed_rows.push_back(row);
    row.it = compute_item(0, 1, 6);                                   directed_rows.push_back(row);
    row.it = compute_item(3, 3, 3);                                   directed_rows.push_back(row);
    row.it = compute_item(3, 4, 5);                                   directed_rows.push_back(row);
    row.it = compute_item(4, 5, 1023);                                directed_rows.push_back(row);
    row.it = compute_item(1023, 3, 4);                                directed_rows.push_back(row);
    row.it = compute_item(5, 1023, 0);                                directed_rows.push_back(row);
    row.it = store_item(7, 32'hffffffff, 32'h00000001, 32'hfffffffe); directed_rows.push_back(row);
    row.it = compute_item(7, 0, 1);                                   directed_rows.push_back(row);
    row.it = compute_item(2, 7, 4);                                   directed_rows.push_back(row);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it);
      if (directed_rows[i].has_fixed) begin
        // Replace the prediction with the value read off the table.
        if (pending_results[$] !== directed_rows[i].fixed) begin
          mismatch_count++;
          $display("predictor disagrees with typed-in row %0d", i);
        end
        pending_results[$] = directed_rows[i].fixed;
      end
    end
    drop_start();

    // Hold off until every result is in.
    while (pending_results.size() != 0) @(posedge clk);

    // Random part: a mix of fresh stores and triangles on known slots,
    // with bursts of back-to-back items and random gaps.
    drained = 0;
    for (int n = 0; n < 1230; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 1230; b++, n++) begin
        if ($urandom_range(0, 99) < 45) begin
          slot = ($urandom_range(0, 3) == 0) ? $urandom_range(1016, 1023)
                                             : $urandom_range(0, 1023);
          it = store_item(slot, pick_coord(), pick_coord(), pick_coord());
          // Sometimes repeat a known vertex to get a collinear triangle.
          if ($urandom_range(0, 9) == 0) begin
            it.coord_x = vtx_mem[known_slots[0]][0];
            it.coord_y = vtx_mem[known_slots[0]][1];
            it.coord_z = vtx_mem[known_slots[0]][2];
          end
        end else begin
          it = compute_item(known_slots[$urandom_range(0, known_slots.size() - 1)],
                            known_slots[$urandom_range(0, known_slots.size() - 1)],
                            known_slots[$urandom_range(0, known_slots.size() - 1)]);
        end
        send_item(it);
      end
      if (!drained && n > 600) begin
        drained = 1;
        drop_start();
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        drop_start();
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    drop_start();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("Covered %0d vertex stores and %0d triangle computes; %0d results checked.",
             store_count, compute_count, result_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
